// ===== design/cbm_pkg.sv =====
// Package for the cartridge bank mapper: operation and target codes, board codes,
// register state types, reset values and the CHR bank pick table.
// No dependencies.
`timescale 1ns / 1ps

package cbm_pkg;

  typedef enum logic [2:0] {
    OP_TICK      = 3'd0,
    OP_REG_WRITE = 3'd1,
    OP_SCR_WRITE = 3'd2,
    OP_SCR_READ  = 3'd3,
    OP_PRG_XLAT  = 3'd4,
    OP_CHR_XLAT  = 3'd5
  } op_t;

  localparam logic [1:0] TGT_PRG_ROM = 2'd0;
  localparam logic [1:0] TGT_PRG_RAM = 2'd1;
  localparam logic [1:0] TGT_OPEN    = 2'd2;
  localparam logic [1:0] TGT_CHR_ROM = 2'd3;

  localparam logic [1:0] BOARD_SUB0 = 2'd0;
  localparam logic [1:0] BOARD_SUB1 = 2'd1;
  localparam logic [1:0] BOARD_WRAM = 2'd2;
  localparam logic [1:0] BOARD_ALT  = 2'd3;

  localparam logic CFG_BOARD_TYPE = 1'b0;
  localparam logic CFG_DIP_VALUE  = 1'b1;

  localparam logic [1:0] GRP_OUTER = 2'd0;
  localparam logic [1:0] GRP_MODE  = 2'd1;
  localparam logic [1:0] GRP_IRQ   = 2'd2;
  localparam logic [1:0] GRP_BANK  = 2'd3;

  localparam logic [1:0] PRG_MODE_16K = 2'd0;
  localparam logic [1:0] PRG_MODE_32K = 2'd1;

  localparam int MODE_ROM6000_BIT = 5;
  localparam int MODE_DOWN_BIT    = 6;
  localparam int MODE_ENABLE_BIT  = 7;

  localparam logic [7:0] MODE_RESET     = 8'h10;
  localparam logic [7:0] PRG_BANK_RESET = 8'hFC;
  localparam logic [3:0] PAGE_SCRATCH   = 4'h5;

  typedef struct packed {
    logic [7:0]       outer;
    logic [7:0]       mode;
    logic [3:0][7:0]  prg;
    logic [7:0][7:0]  chr;
  } bank_state_t;

  typedef struct packed {
    logic [21:0] maddr;
    logic [1:0]  tgt;
  } xlat_t;

  typedef struct packed {
    logic [7:0]  read_data;
    logic [21:0] maddr;
    logic [1:0]  tgt;
    logic        irq;
    logic [1:0]  nt_mode;
  } result_t;

  function automatic logic [2:0] chr_pick(input logic [1:0] quarter);
    logic [2:0] sel;
    case (quarter)
      2'd0:    sel = 3'd0;
      2'd1:    sel = 3'd1;
      2'd2:    sel = 3'd6;
      default: sel = 3'd7;
    endcase
    return sel;
  endfunction

endpackage

// ===== design/cbm_translate.sv =====
// Combinational PRG and CHR address translation for the cartridge bank mapper.
// Depends on cbm_pkg.
`timescale 1ns / 1ps

module cbm_translate (
  input  logic [1:0]          board,
  input  cbm_pkg::bank_state_t st,
  input  logic [15:0]         addr,
  input  logic                is_chr,
  output cbm_pkg::xlat_t      res
);

  logic [4:0]  pm;
  logic [8:0]  pm9;
  logic [7:0]  bank16;
  logic [7:0]  inner;
  logic [8:0]  bank8k;
  logic [1:0]  cmode;
  logic [9:0]  chr_bank;
  cbm_pkg::xlat_t prg_res;
  logic [21:0] chr_addr;

  assign pm  = (board == cbm_pkg::BOARD_ALT) ? 5'h0F : 5'h1F;
  assign pm9 = {4'b0, pm};
  assign bank16 = (addr[15:14] == 2'b11) ? (st.outer | {4'b0, pm[4:1]}) : st.outer;
  assign inner  = (addr[14:13] == 2'b11) ? 8'h1F : st.prg[addr[14:13]];
  assign bank8k = ({st.outer, 1'b0} & ~pm9) | ({1'b0, inner} & pm9);

  always_comb begin
    prg_res.maddr = '0;
    prg_res.tgt   = cbm_pkg::TGT_OPEN;
    if (addr[15]) begin
      prg_res.tgt = cbm_pkg::TGT_PRG_ROM;
      case (st.mode[4:3])
        cbm_pkg::PRG_MODE_16K: prg_res.maddr = {bank16, addr[13:0]};
        cbm_pkg::PRG_MODE_32K: prg_res.maddr = {st.outer[7:1], addr[14:0]};
        default:               prg_res.maddr = {bank8k, addr[12:0]};
      endcase
    end else if (addr[14:13] == 2'b11) begin
      if (board == cbm_pkg::BOARD_WRAM) begin
        prg_res.tgt   = cbm_pkg::TGT_PRG_RAM;
        prg_res.maddr = {7'b0, st.outer[7:6], addr[12:0]};
      end else if (st.mode[cbm_pkg::MODE_ROM6000_BIT]) begin
        prg_res.tgt   = cbm_pkg::TGT_PRG_ROM;
        prg_res.maddr = {1'b0, st.prg[3], addr[12:0]};
      end
    end
  end

  assign cmode    = (board == cbm_pkg::BOARD_ALT) ? cbm_pkg::BOARD_SUB1 : board;
  assign chr_bank = {2'b0, st.chr[addr[12:10]]}
                  | ((cmode == cbm_pkg::BOARD_WRAM) ? {st.outer[5:4], 8'b0} : 10'b0);

  always_comb begin
    if (cmode == cbm_pkg::BOARD_SUB1) begin
      chr_addr = {3'b0, st.chr[cbm_pkg::chr_pick(addr[12:11])], addr[10:0]};
    end else begin
      chr_addr = {2'b0, chr_bank, addr[9:0]};
    end
  end

  always_comb begin
    if (is_chr) begin
      res.maddr = chr_addr;
      res.tgt   = cbm_pkg::TGT_CHR_ROM;
    end else begin
      res = prg_res;
    end
  end

endmodule

// ===== design/cbm_core.sv =====
// Mapper state and single-pass item execution: bank, mode, scratch and IRQ registers.
// Depends on cbm_pkg and cbm_translate.
`timescale 1ns / 1ps

module cbm_core (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_we,
  input  logic              cfg_index,
  input  logic [7:0]        cfg_wdata,
  input  logic              step_en,
  input  logic [2:0]        op,
  input  logic [15:0]       addr,
  input  logic [7:0]        wdata,
  output cbm_pkg::result_t  res
);

  logic [1:0]           board_r;
  logic [7:0]           dip_r;
  cbm_pkg::bank_state_t st_r, st_nxt;
  logic [3:0][7:0]      scr_r, scr_nxt;
  logic [15:0]          cnt_r, cnt_nxt;
  logic                 active_r, active_nxt;
  logic                 irq_r, irq_nxt;

  logic [15:0]    cnt_step;
  logic [15:0]    reg_addr;
  logic           page5;
  logic           dip_sel;
  logic [7:0]     rd;
  cbm_pkg::xlat_t xl;
  logic           is_xlat;

  cbm_translate u_xlat (
    .board  (board_r),
    .st     (st_r),
    .addr   (addr),
    .is_chr (cbm_pkg::op_t'(op) == cbm_pkg::OP_CHR_XLAT),
    .res    (xl)
  );

  assign cnt_step = st_r.mode[cbm_pkg::MODE_DOWN_BIT] ? (cnt_r - 16'd1) : (cnt_r + 16'd1);
  assign reg_addr = (board_r == cbm_pkg::BOARD_ALT)
                  ? {2'b0, addr[15:8], addr[5:0]} : addr;
  assign page5    = (addr[15:12] == cbm_pkg::PAGE_SCRATCH);
  assign dip_sel  = (board_r == cbm_pkg::BOARD_ALT) ? addr[10] : addr[8];

  always_comb begin
    st_nxt     = st_r;
    scr_nxt    = scr_r;
    cnt_nxt    = cnt_r;
    active_nxt = active_r;
    irq_nxt    = irq_r;
    rd         = 8'd0;
    is_xlat    = 1'b0;
    case (cbm_pkg::op_t'(op))
      cbm_pkg::OP_TICK: begin
        if (active_r && (cnt_r != 16'd0)) begin
          cnt_nxt = cnt_step;
          if (cnt_step == 16'd0) begin
            irq_nxt    = 1'b1;
            active_nxt = 1'b0;
          end
        end
      end
      cbm_pkg::OP_REG_WRITE: begin
        if (addr[15]) begin
          case (reg_addr[9:8])
            cbm_pkg::GRP_OUTER: st_nxt.outer = wdata;
            cbm_pkg::GRP_MODE:  st_nxt.mode  = wdata;
            cbm_pkg::GRP_IRQ: begin
              if (reg_addr[0]) begin
                cnt_nxt[15:8] = wdata;
                active_nxt    = st_r.mode[cbm_pkg::MODE_ENABLE_BIT];
              end else begin
                cnt_nxt[7:0] = wdata;
                irq_nxt      = 1'b0;
              end
            end
            default: begin
              if (!reg_addr[4]) begin
                st_nxt.prg[reg_addr[1:0]] = wdata;
              end else if (!reg_addr[3]) begin
                st_nxt.chr[reg_addr[2:0]] = wdata;
              end
            end
          endcase
        end
      end
      cbm_pkg::OP_SCR_WRITE: begin
        if (page5) begin
          scr_nxt[addr[1:0]] = wdata;
        end
      end
      cbm_pkg::OP_SCR_READ: begin
        if (page5) begin
          rd = dip_sel ? scr_r[addr[1:0]] : dip_r;
        end
      end
      cbm_pkg::OP_PRG_XLAT: is_xlat = 1'b1;
      cbm_pkg::OP_CHR_XLAT: is_xlat = 1'b1;
      default: ;
    endcase
  end

  always_comb begin
    res.read_data = rd;
    res.maddr     = is_xlat ? xl.maddr : 22'd0;
    res.tgt       = is_xlat ? xl.tgt : cbm_pkg::TGT_OPEN;
    res.irq       = irq_nxt;
    res.nt_mode   = st_nxt.mode[1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      board_r <= cbm_pkg::BOARD_SUB0;
      dip_r   <= 8'd0;
    end else if (cfg_we) begin
      case (cfg_index)
        cbm_pkg::CFG_BOARD_TYPE: board_r <= cfg_wdata[1:0];
        cbm_pkg::CFG_DIP_VALUE:  dip_r   <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r.outer <= 8'd0;
      st_r.mode  <= cbm_pkg::MODE_RESET;
      for (int i = 0; i < 4; i++) begin
        st_r.prg[i] <= cbm_pkg::PRG_BANK_RESET | 8'(i);
        scr_r[i]    <= 8'd0;
      end
      for (int i = 0; i < 8; i++) begin
        st_r.chr[i] <= 8'(i);
      end
      cnt_r    <= 16'd0;
      active_r <= 1'b0;
      irq_r    <= 1'b0;
    end else if (step_en) begin
      st_r     <= st_nxt;
      scr_r    <= scr_nxt;
      cnt_r    <= cnt_nxt;
      active_r <= active_nxt;
      irq_r    <= irq_nxt;
    end
  end

endmodule

// ===== design/cartridge_bank_mapper_irq.sv =====
// Cartridge bank mapper with IRQ counter: input register, mapper core, result register.
// Items pass the input register, then the core, into the result register (two register stages).
// Throughput: one item per cycle while out_ready does not stall it; the core executes each item in a single pass.
// The result register decouples the sides, so an empty input register takes an item while a result waits.
// Reset (rst_n low, synchronous) empties both stages and restores all mapper state.
// Depends on cbm_pkg and cbm_core.
`timescale 1ns / 1ps

module cartridge_bank_mapper_irq (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [7:0]  cfg_wdata,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [2:0]  in_operation,
  input  logic [15:0] in_address,
  input  logic [7:0]  in_write_data,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  out_read_data,
  output logic [21:0] out_mapped_address,
  output logic [1:0]  out_target,
  output logic        out_irq,
  output logic [1:0]  out_nametable_mode
);

  logic             s1_valid_r, s1_valid_nxt;
  logic [2:0]       s1_op_r;
  logic [15:0]      s1_addr_r;
  logic [7:0]       s1_data_r;
  logic             out_valid_r, out_valid_nxt;
  cbm_pkg::result_t out_res_r;
  cbm_pkg::result_t core_res;
  logic             advance;
  logic             step_en;
  logic             in_take;

  assign advance  = !out_valid_r || out_ready;
  assign step_en  = s1_valid_r && advance;
  assign in_ready = !s1_valid_r || advance;
  assign in_take  = in_valid && in_ready;

  assign s1_valid_nxt  = in_take ? 1'b1 : (step_en ? 1'b0 : s1_valid_r);
  assign out_valid_nxt = advance ? s1_valid_r : out_valid_r;

  cbm_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .step_en   (step_en),
    .op        (s1_op_r),
    .addr      (s1_addr_r),
    .wdata     (s1_data_r),
    .res       (core_res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_op_r   <= in_operation;
      s1_addr_r <= in_address;
      s1_data_r <= in_write_data;
    end
    if (step_en) begin
      out_res_r <= core_res;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_read_data      = out_res_r.read_data;
  assign out_mapped_address = out_res_r.maddr;
  assign out_target         = out_res_r.tgt;
  assign out_irq            = out_res_r.irq;
  assign out_nametable_mode = out_res_r.nt_mode;

endmodule

// ===== design/cbm_checker.sv =====
// Port-level assertions for the cartridge bank mapper, bound to the top level.
// Depends on cbm_pkg and cartridge_bank_mapper_irq.
`timescale 1ns / 1ps

module cbm_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_ready,
  input logic [7:0]  out_read_data,
  input logic [21:0] out_mapped_address,
  input logic [1:0]  out_target,
  input logic        out_irq,
  input logic [1:0]  out_nametable_mode
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_read_data)
      && $stable(out_mapped_address) && $stable(out_target)
      && $stable(out_irq) && $stable(out_nametable_mode))
    else $error("Stalled result item changed.");

  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("Result valid right after reset.");

  a_chr_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_target == cbm_pkg::TGT_CHR_ROM) |-> out_mapped_address[21:20] == 2'b00)
    else $error("CHR address beyond its range.");

  a_open_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_target == cbm_pkg::TGT_OPEN) |-> out_mapped_address == 22'd0)
    else $error("Open bus item carries an address.");

  a_read_not_xlat: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_read_data != 8'd0) |-> out_target == cbm_pkg::TGT_OPEN)
    else $error("Read data on a translation item.");

endmodule

bind cartridge_bank_mapper_irq cbm_checker u_cbm_checker (
  .clk                (clk),
  .rst_n              (rst_n),
  .out_valid          (out_valid),
  .out_ready          (out_ready),
  .out_read_data      (out_read_data),
  .out_mapped_address (out_mapped_address),
  .out_target         (out_target),
  .out_irq            (out_irq),
  .out_nametable_mode (out_nametable_mode)
);

// ===== tb/cartridge_bank_mapper_irq_tb.sv =====
// Self-checking testbench for cartridge_bank_mapper_irq: directed bus items, then random
// traffic under every board type, checked against an in-bench model of the mapper.
// Depends on cbm_pkg and the design files only.
`timescale 1ns / 1ps

module cartridge_bank_mapper_irq_tb;

  localparam logic [2:0] OP_RSVD_A = 3'd6;
  localparam logic [2:0] OP_RSVD_B = 3'd7;
  localparam int CYCLE_LIMIT = 400000;
  localparam int SETTLE_CYCLES = 6;
  localparam int DRAIN_CYCLES = 10;
  localparam int ITEMS_PER_PHASE = 225;

  typedef struct packed {
    logic [2:0]       op;
    logic [15:0]      addr;
    logic [7:0]       data;
    logic             pinned;
    cbm_pkg::result_t res;
  } stim_row_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_we = 1'b0;
  logic        cfg_index = 1'b0;
  logic [7:0]  cfg_wdata = 8'd0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [2:0]  in_operation = 3'd0;
  logic [15:0] in_address = 16'd0;
  logic [7:0]  in_write_data = 8'd0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [7:0]  out_read_data;
  logic [21:0] out_mapped_address;
  logic [1:0]  out_target;
  logic        out_irq;
  logic [1:0]  out_nametable_mode;

  cartridge_bank_mapper_irq uut (
    .clk(clk), .rst_n(rst_n),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
    .in_valid(in_valid), .in_ready(in_ready), .in_operation(in_operation),
    .in_address(in_address), .in_write_data(in_write_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_read_data(out_read_data),
    .out_mapped_address(out_mapped_address), .out_target(out_target),
    .out_irq(out_irq), .out_nametable_mode(out_nametable_mode)
  );

  // Model state of the mapper.
  logic [1:0]  board;
  logic [7:0]  dip;
  logic [7:0]  outer_bank;
  logic [7:0]  mode_byte;
  logic [7:0]  prg_bank [4];
  logic [7:0]  chr_bank [8];
  logic [7:0]  scratch [4];
  logic [15:0] irq_count;
  logic        counting;
  logic        irq_pending;

  cbm_pkg::result_t results_due [$];
  stim_row_t        directed_rows [$];
  int               items_sent = 0;
  int               results_seen = 0;
  int               mismatch_count = 0;
  int               irq_events = 0;
  int               phases = 0;
  int               cycle_count = 0;
  int               stall_left = 0;
  bit               steady = 1'b0;

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic stim_row_t checked_row(input logic [2:0] op, input logic [15:0] a,
                                            input logic [7:0] v);
    stim_row_t row;
    row = '0;
    row.op = op;
    row.addr = a;
    row.data = v;
    return row;
  endfunction

  function automatic stim_row_t pinned_row(input logic [2:0] op, input logic [15:0] a,
                                           input logic [7:0] v, input logic [7:0] rd,
                                           input logic [21:0] maddr, input logic [1:0] tgt,
                                           input logic irq, input logic [1:0] nt);
    stim_row_t row;
    row = checked_row(op, a, v);
    row.pinned = 1'b1;
    row.res = {rd, maddr, tgt, irq, nt};
    return row;
  endfunction

  function automatic void write_bank_reg(input logic [15:0] a, input logic [7:0] v);
    logic [15:0] sa;
    logic [4:0]  idx;
    sa = (board == cbm_pkg::BOARD_ALT) ? (((a >> 2) & 16'h3FC0) | (a & 16'h003F)) : a;
    idx = sa[4:0];
    case (sa[9:8])
      cbm_pkg::GRP_OUTER: outer_bank = v;
      cbm_pkg::GRP_MODE:  mode_byte = v;
      cbm_pkg::GRP_IRQ: begin
        if (idx[0]) begin
          irq_count[15:8] = v;
          counting = mode_byte[cbm_pkg::MODE_ENABLE_BIT];
        end else begin
          irq_count[7:0] = v;
          irq_pending = 1'b0;
        end
      end
      default: begin
        if (idx < 5'h10) prg_bank[idx[1:0]] = v;
        else if (idx < 5'h18) chr_bank[idx[2:0]] = v;
      end
    endcase
  endfunction

  // Applies one bus item to the model and returns the result it produces.
  function automatic cbm_pkg::result_t mapper_step(input logic [2:0] op, input logic [15:0] a,
                                                   input logic [7:0] v);
    cbm_pkg::result_t r;
    int unsigned      maddr, bank, inner, pmask;
    logic             page5;
    logic             dip_bit;
    r = '0;
    r.tgt = cbm_pkg::TGT_OPEN;
    maddr = 0;
    pmask = (board == cbm_pkg::BOARD_ALT) ? 32'h0F : 32'h1F;
    page5 = (a[15:12] == cbm_pkg::PAGE_SCRATCH);
    dip_bit = (board == cbm_pkg::BOARD_ALT) ? a[10] : a[8];
    case (op)
      cbm_pkg::OP_TICK: begin
        if (counting && irq_count != 16'd0) begin
          if (mode_byte[cbm_pkg::MODE_DOWN_BIT]) irq_count = irq_count - 16'd1;
          else irq_count = irq_count + 16'd1;
          if (irq_count == 16'd0) begin
            irq_pending = 1'b1;
            counting = 1'b0;
            irq_events++;
          end
        end
      end
      cbm_pkg::OP_REG_WRITE: if (a[15]) write_bank_reg(a, v);
      cbm_pkg::OP_SCR_WRITE: if (page5) scratch[a[1:0]] = v;
      cbm_pkg::OP_SCR_READ: begin
        if (page5) r.read_data = dip_bit ? scratch[a[1:0]] : dip;
      end
      cbm_pkg::OP_PRG_XLAT: begin
        if (a >= 16'h8000) begin
          r.tgt = cbm_pkg::TGT_PRG_ROM;
          if (mode_byte[4:3] == cbm_pkg::PRG_MODE_16K) begin
            bank = (a < 16'hC000) ? 32'(outer_bank) : (32'(outer_bank) | (pmask >> 1));
            maddr = bank * 32'h4000 + a[13:0];
          end else if (mode_byte[4:3] == cbm_pkg::PRG_MODE_32K) begin
            maddr = (32'(outer_bank) >> 1) * 32'h8000 + a[14:0];
          end else begin
            inner = (a[14:13] == 2'd3) ? 32'h1F : 32'(prg_bank[a[14:13]]);
            bank = ((32'(outer_bank) << 1) & ~pmask & 32'h1FF) | (inner & pmask);
            maddr = bank * 32'h2000 + a[12:0];
          end
        end else if (a >= 16'h6000) begin
          if (board == cbm_pkg::BOARD_WRAM) begin
            r.tgt = cbm_pkg::TGT_PRG_RAM;
            maddr = (32'(outer_bank) >> 6) * 32'h2000 + a[12:0];
          end else if (mode_byte[cbm_pkg::MODE_ROM6000_BIT]) begin
            r.tgt = cbm_pkg::TGT_PRG_ROM;
            maddr = 32'(prg_bank[3]) * 32'h2000 + a[12:0];
          end
        end
      end
      cbm_pkg::OP_CHR_XLAT: begin
        r.tgt = cbm_pkg::TGT_CHR_ROM;
        if (board == cbm_pkg::BOARD_SUB1 || board == cbm_pkg::BOARD_ALT) begin
          case (a[12:11])
            2'd0:    bank = chr_bank[0];
            2'd1:    bank = chr_bank[1];
            2'd2:    bank = chr_bank[6];
            default: bank = chr_bank[7];
          endcase
          maddr = bank * 32'h800 + a[10:0];
        end else begin
          bank = chr_bank[a[12:10]];
          if (board == cbm_pkg::BOARD_WRAM) bank = bank | ((32'(outer_bank) << 4) & 32'h300);
          maddr = bank * 32'h400 + a[9:0];
        end
      end
      default: ;
    endcase
    r.maddr = maddr[21:0];
    r.irq = irq_pending;
    r.nt_mode = mode_byte[1:0];
    return r;
  endfunction

  function automatic int idle_span();
    int r;
    r = $urandom_range(0, 99);
    if (steady || r < 65) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(4, 20);
  endfunction

  function automatic logic [15:0] reg_addr(input logic [1:0] grp, input logic [4:0] idx);
    logic [15:0] a;
    a = 16'($urandom);
    a[15] = 1'b1;
    a[4:0] = idx;
    if (board == cbm_pkg::BOARD_ALT) a[11:10] = grp;
    else a[9:8] = grp;
    return a;
  endfunction

  function automatic logic [15:0] scratch_addr();
    if ($urandom_range(0, 4) != 0) return {cbm_pkg::PAGE_SCRATCH, 12'($urandom)};
    return 16'($urandom);
  endfunction

  task automatic issue_item(input logic [2:0] op, input logic [15:0] a, input logic [7:0] v,
                            input logic pinned, input cbm_pkg::result_t pinned_res);
    int               gap;
    cbm_pkg::result_t predicted;
    gap = idle_span();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_operation <= op;
    in_address <= a;
    in_write_data <= v;
    do @(posedge clk); while (!in_ready);
    predicted = mapper_step(op, a, v);
    results_due.push_back(pinned ? pinned_res : predicted);
    items_sent++;
    if ($urandom_range(0, 63) == 0) steady <= !steady;
  endtask

  task automatic configure(input logic [1:0] new_board, input logic [7:0] new_dip);
    in_valid <= 1'b0;
    while (results_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= cbm_pkg::CFG_BOARD_TYPE;
    cfg_wdata <= {6'd0, new_board};
    @(posedge clk);
    cfg_index <= cbm_pkg::CFG_DIP_VALUE;
    cfg_wdata <= new_dip;
    @(posedge clk);
    cfg_we <= 1'b0;
    board = new_board;
    dip = new_dip;
    phases++;
  endtask

  task automatic random_item();
    int r;
    r = $urandom_range(0, 99);
    if (r < 18) begin
      issue_item(cbm_pkg::OP_TICK, 16'($urandom), 8'($urandom), 1'b0, '0);
    end else if (r < 40) begin
      if ($urandom_range(0, 6) != 0)
        issue_item(cbm_pkg::OP_REG_WRITE, reg_addr(2'($urandom), 5'($urandom)),
                   8'($urandom), 1'b0, '0);
      else
        issue_item(cbm_pkg::OP_REG_WRITE, 16'($urandom), 8'($urandom), 1'b0, '0);
    end else if (r < 48) begin
      issue_item(cbm_pkg::OP_SCR_WRITE, scratch_addr(), 8'($urandom), 1'b0, '0);
    end else if (r < 60) begin
      issue_item(cbm_pkg::OP_SCR_READ, scratch_addr(), 8'($urandom), 1'b0, '0);
    end else if (r < 78) begin
      issue_item(cbm_pkg::OP_PRG_XLAT, 16'($urandom), 8'($urandom), 1'b0, '0);
    end else if (r < 94) begin
      issue_item(cbm_pkg::OP_CHR_XLAT, 16'($urandom), 8'($urandom), 1'b0, '0);
    end else begin
      issue_item($urandom_range(0, 1) ? OP_RSVD_A : OP_RSVD_B, 16'($urandom), 8'($urandom),
                 1'b0, '0);
    end
  endtask

  // Mostly random items; now and then programs the counter to expire within 1 to 12 ticks, then issues ticks.
  task automatic random_phase(input int count);
    int         stop_at, n;
    logic       down;
    logic [7:0] lo, hi;
    stop_at = items_sent + count;
    while (items_sent < stop_at) begin
      if ($urandom_range(0, 99) < 8) begin
        down = 1'($urandom_range(0, 1));
        issue_item(cbm_pkg::OP_REG_WRITE, reg_addr(cbm_pkg::GRP_MODE, 5'($urandom)),
                   {1'b1, down, 6'($urandom)}, 1'b0, '0);
        if (down) begin
          lo = 8'($urandom_range(1, 12));
          hi = 8'h00;
        end else begin
          lo = 8'($urandom_range(8'hF4, 8'hFF));
          hi = 8'hFF;
        end
        issue_item(cbm_pkg::OP_REG_WRITE, reg_addr(cbm_pkg::GRP_IRQ, {4'($urandom), 1'b0}),
                   lo, 1'b0, '0);
        issue_item(cbm_pkg::OP_REG_WRITE, reg_addr(cbm_pkg::GRP_IRQ, {4'($urandom), 1'b1}),
                   hi, 1'b0, '0);
        n = $urandom_range(2, 16);
        repeat (n) begin
          if ($urandom_range(0, 99) < 20) random_item();
          else issue_item(cbm_pkg::OP_TICK, 16'($urandom), 8'($urandom), 1'b0, '0);
        end
      end else begin
        random_item();
      end
    end
  endtask

  task automatic report_mismatch(input string what, input cbm_pkg::result_t want,
                                 input cbm_pkg::result_t seen);
    if (mismatch_count < 10) begin
      $display("Mismatch at cycle %0d, %s: expected rd=%02h addr=%06h tgt=%0d irq=%0b nt=%0d",
               cycle_count, what, want.read_data, want.maddr, want.tgt, want.irq,
               want.nt_mode);
      $display("  actual rd=%02h addr=%06h tgt=%0d irq=%0b nt=%0d",
               seen.read_data, seen.maddr, seen.tgt, seen.irq, seen.nt_mode);
    end
    mismatch_count++;
  endtask

  always @(posedge clk) begin
    cbm_pkg::result_t seen, want;
    int               r;
    if (rst_n && out_valid && out_ready) begin
      seen = {out_read_data, out_mapped_address, out_target, out_irq, out_nametable_mode};
      if (results_due.size() == 0) begin
        report_mismatch("result with no item pending", '0, seen);
      end else begin
        want = results_due.pop_front();
        results_seen++;
        if (seen.read_data !== want.read_data || seen.maddr !== want.maddr ||
            seen.tgt !== want.tgt || seen.irq !== want.irq || seen.nt_mode !== want.nt_mode)
          report_mismatch("wrong field", want, seen);
      end
    end
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_ready <= 1'b0;
    end else begin
      r = $urandom_range(0, 99);
      if (steady || r < 70) begin
        out_ready <= 1'b1;
      end else begin
        out_ready <= 1'b0;
        stall_left <= (r < 95) ? $urandom_range(0, 2) : $urandom_range(4, 24);
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles with %0d results outstanding",
               cycle_count, results_due.size());
      $display("Verification failed");
      $finish;
    end
  end

  initial begin
    board = cbm_pkg::BOARD_SUB0;
    dip = 8'd0;
    outer_bank = 8'd0;
    mode_byte = cbm_pkg::MODE_RESET;
    for (int i = 0; i < 4; i++) prg_bank[i] = cbm_pkg::PRG_BANK_RESET | 8'(i);
    for (int i = 0; i < 8; i++) chr_bank[i] = 8'(i);
    for (int i = 0; i < 4; i++) scratch[i] = 8'd0;
    irq_count = 16'd0;
    counting = 1'b0;
    irq_pending = 1'b0;

    // Reset state with board 0 and DIP 5A: open bus, DIP and scratch reads, a scratch write, an ignored write.
    directed_rows.push_back(pinned_row(cbm_pkg::OP_PRG_XLAT, 16'h0000, 8'h00,
                                       8'h00, 22'd0, cbm_pkg::TGT_OPEN, 1'b0, 2'd0));
    directed_rows.push_back(pinned_row(cbm_pkg::OP_PRG_XLAT, 16'h6000, 8'h00,
                                       8'h00, 22'd0, cbm_pkg::TGT_OPEN, 1'b0, 2'd0));
    directed_rows.push_back(pinned_row(cbm_pkg::OP_SCR_READ, 16'h4003, 8'h00,
                                       8'h00, 22'd0, cbm_pkg::TGT_OPEN, 1'b0, 2'd0));
    directed_rows.push_back(pinned_row(cbm_pkg::OP_SCR_READ, 16'h5000, 8'h00,
                                       8'h5A, 22'd0, cbm_pkg::TGT_OPEN, 1'b0, 2'd0));
    directed_rows.push_back(pinned_row(cbm_pkg::OP_SCR_WRITE, 16'h5FFF, 8'hFF,
                                       8'h00, 22'd0, cbm_pkg::TGT_OPEN, 1'b0, 2'd0));
    directed_rows.push_back(pinned_row(cbm_pkg::OP_SCR_READ, 16'h5103, 8'h00,
                                       8'hFF, 22'd0, cbm_pkg::TGT_OPEN, 1'b0, 2'd0));
    directed_rows.push_back(pinned_row(cbm_pkg::OP_REG_WRITE, 16'h7FFF, 8'hFF,
                                       8'h00, 22'd0, cbm_pkg::TGT_OPEN, 1'b0, 2'd0));
    directed_rows.push_back(pinned_row(cbm_pkg::OP_CHR_XLAT, 16'hFFFF, 8'h00,
                                       8'h00, 22'h001FFF, cbm_pkg::TGT_CHR_ROM, 1'b0, 2'd0));
    directed_rows.push_back(checked_row(cbm_pkg::OP_PRG_XLAT, 16'hFFFF, 8'h00));
    directed_rows.push_back(pinned_row(cbm_pkg::OP_REG_WRITE, 16'h8100, 8'hE3,
                                       8'h00, 22'd0, cbm_pkg::TGT_OPEN, 1'b0, 2'd3));
    // Count down from two, then one tick past zero.
    directed_rows.push_back(checked_row(cbm_pkg::OP_REG_WRITE, 16'h8200, 8'h02));
    directed_rows.push_back(checked_row(cbm_pkg::OP_REG_WRITE, 16'h8201, 8'h00));
    directed_rows.push_back(checked_row(cbm_pkg::OP_TICK, 16'h0000, 8'h00));
    directed_rows.push_back(checked_row(cbm_pkg::OP_TICK, 16'hFFFF, 8'hFF));
    directed_rows.push_back(checked_row(cbm_pkg::OP_TICK, 16'h0000, 8'h00));
    directed_rows.push_back(checked_row(cbm_pkg::OP_REG_WRITE, 16'h831F, 8'hAA));
    directed_rows.push_back(checked_row(cbm_pkg::OP_REG_WRITE, 16'h8303, 8'h80));
    directed_rows.push_back(checked_row(cbm_pkg::OP_PRG_XLAT, 16'h7FFF, 8'h00));
    directed_rows.push_back(checked_row(cbm_pkg::OP_PRG_XLAT, 16'h8000, 8'h00));
    directed_rows.push_back(checked_row(cbm_pkg::OP_PRG_XLAT, 16'hC000, 8'h00));
    directed_rows.push_back(checked_row(cbm_pkg::OP_REG_WRITE, 16'h8200, 8'h00));
    directed_rows.push_back(checked_row(cbm_pkg::OP_REG_WRITE, 16'h8000, 8'hFF));
    directed_rows.push_back(checked_row(OP_RSVD_A, 16'hFFFF, 8'hFF));
    directed_rows.push_back(checked_row(OP_RSVD_B, 16'h0000, 8'h00));
    directed_rows.push_back(checked_row(cbm_pkg::OP_REG_WRITE, 16'h8108, 8'h00));
    directed_rows.push_back(checked_row(cbm_pkg::OP_PRG_XLAT, 16'hFFFF, 8'h00));
    directed_rows.push_back(checked_row(cbm_pkg::OP_CHR_XLAT, 16'h0000, 8'h00));

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    configure(cbm_pkg::BOARD_SUB0, 8'h5A);
    foreach (directed_rows[i])
      issue_item(directed_rows[i].op, directed_rows[i].addr, directed_rows[i].data,
                 directed_rows[i].pinned, directed_rows[i].res);

    configure(cbm_pkg::BOARD_SUB1, 8'hFF);
    random_phase(ITEMS_PER_PHASE);
    configure(cbm_pkg::BOARD_WRAM, 8'h00);
    random_phase(ITEMS_PER_PHASE);
    configure(cbm_pkg::BOARD_ALT, 8'($urandom));
    random_phase(ITEMS_PER_PHASE);
    configure(cbm_pkg::BOARD_SUB0, 8'($urandom));
    random_phase(ITEMS_PER_PHASE);
    configure(cbm_pkg::BOARD_ALT, 8'hA5);
    random_phase(ITEMS_PER_PHASE);

    in_valid <= 1'b0;
    while (results_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Sent %0d items across %0d board settings; %0d results checked, %0d mismatches.",
             items_sent, phases, results_seen, mismatch_count);
    $display("The counter expired %0d times in the model.", irq_events);
    if (mismatch_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
